### hdl/nearest_point_bin_lookup_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef NEAREST_POINT_BIN_LOOKUP_UNIT_MACROS_SVH
`define NEAREST_POINT_BIN_LOOKUP_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define NPBL_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define NPBL_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");

`endif

### hdl/npbl_pkg.sv
package npbl_pkg;

   localparam int TABLE_DEPTH    = 4096;
   localparam int COORD_BITS     = 16;
   localparam int BIN_BITS       = 8;
   localparam int BIN_OUT_BITS   = BIN_BITS + 1;
   localparam int INDEX_BITS     = 12;
   localparam int COUNT_BITS     = 13;
   localparam int LIMIT_BITS     = 35;
   localparam int CSR_DATA_BITS  = 35;
   localparam int CSR_INDEX_BITS = 1;

   localparam int ADDR_BITS = $clog2(TABLE_DEPTH);
   localparam int SCAN_BITS = ADDR_BITS + 1;

   // Distance datapath widths: difference, magnitude, square and sum.
   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int MAG_BITS  = COORD_BITS + 1;
   localparam int SQ_BITS   = 2 * COORD_BITS + 1;
   localparam int SUM_BITS  = SQ_BITS + 1;
   localparam int DIST_BITS = (SUM_BITS > LIMIT_BITS) ? SUM_BITS : LIMIT_BITS;

   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 35'd1677721600;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ENTRY_COUNT    = 1'b0,
      CSR_DISTANCE_LIMIT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                         mode;
      logic [INDEX_BITS-1:0]        entry_index;
      logic signed [COORD_BITS-1:0] coord_a;
      logic signed [COORD_BITS-1:0] coord_b;
      logic signed [BIN_BITS-1:0]   entry_bin;
   } req_word_type;

   typedef struct packed {
      logic signed [BIN_OUT_BITS-1:0] bin_result;
      logic [INDEX_BITS-1:0]          nearest_index;
      logic                           within_limit;
   } rsp_word_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] point_a;
      logic signed [COORD_BITS-1:0] point_b;
      logic signed [BIN_BITS-1:0]   bin;
   } table_word_type;

   localparam int TABLE_WORD_BITS = $bits(table_word_type);

   typedef struct packed {
      logic                  valid;
      logic                  busy;
      logic [ADDR_BITS-1:0]  index;
      logic [DIST_BITS-1:0]  distance;
   } dist_out_type;

endpackage

### hdl/npbl_ram.sv
module npbl_ram #(
   parameter int WIDTH     = 8,
   parameter int DEPTH     = 16,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/npbl_dist_unit.sv
module npbl_dist_unit import npbl_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [ADDR_BITS-1:0]         in_index,
   input  logic signed [COORD_BITS-1:0] entry_a,
   input  logic signed [COORD_BITS-1:0] entry_b,
   input  logic signed [COORD_BITS-1:0] query_a,
   input  logic signed [COORD_BITS-1:0] query_b,
   output dist_out_type                 dist_out
);

   // Stage 1: differences.
   logic                        s1_valid_ff, s1_valid_in;
   logic [ADDR_BITS-1:0]        s1_index_ff;
   logic signed [DIFF_BITS-1:0] s1_diff_a_ff, s1_diff_a_in;
   logic signed [DIFF_BITS-1:0] s1_diff_b_ff, s1_diff_b_in;
   // Stage 2: squares.
   logic                        s2_valid_ff, s2_valid_in;
   logic [ADDR_BITS-1:0]        s2_index_ff;
   logic [SQ_BITS-1:0]          s2_sq_a_ff, s2_sq_a_in;
   logic [SQ_BITS-1:0]          s2_sq_b_ff, s2_sq_b_in;
   // Stage 3: sum.
   logic                        s3_valid_ff, s3_valid_in;
   logic [ADDR_BITS-1:0]        s3_index_ff;
   logic [DIST_BITS-1:0]        s3_dist_ff, s3_dist_in;

   logic [MAG_BITS-1:0]         mag_a, mag_b;
   logic [2*MAG_BITS-1:0]       prod_a, prod_b;

   always_comb begin
      s1_valid_in  = in_valid;
      s1_diff_a_in = DIFF_BITS'(entry_a) - DIFF_BITS'(query_a);
      s1_diff_b_in = DIFF_BITS'(entry_b) - DIFF_BITS'(query_b);

      mag_a  = s1_diff_a_ff[DIFF_BITS-1] ? MAG_BITS'(-s1_diff_a_ff) : MAG_BITS'(s1_diff_a_ff);
      mag_b  = s1_diff_b_ff[DIFF_BITS-1] ? MAG_BITS'(-s1_diff_b_ff) : MAG_BITS'(s1_diff_b_ff);
      prod_a = mag_a * mag_a;
      prod_b = mag_b * mag_b;
      s2_valid_in = s1_valid_ff;
      s2_sq_a_in  = prod_a[SQ_BITS-1:0];
      s2_sq_b_in  = prod_b[SQ_BITS-1:0];

      s3_valid_in = s2_valid_ff;
      s3_dist_in  = DIST_BITS'({1'b0, s2_sq_a_ff} + {1'b0, s2_sq_b_ff});
   end

   always_ff @(posedge clock) begin
      s1_index_ff  <= in_index;
      s1_diff_a_ff <= s1_diff_a_in;
      s1_diff_b_ff <= s1_diff_b_in;
      s2_index_ff  <= s1_index_ff;
      s2_sq_a_ff   <= s2_sq_a_in;
      s2_sq_b_ff   <= s2_sq_b_in;
      s3_index_ff  <= s2_index_ff;
      s3_dist_ff   <= s3_dist_in;
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   assign dist_out.valid    = s3_valid_ff;
   assign dist_out.busy     = s1_valid_ff | s2_valid_ff | s3_valid_ff;
   assign dist_out.index    = s3_index_ff;
   assign dist_out.distance = s3_dist_ff;

endmodule

### hdl/nearest_point_bin_lookup_unit.sv
// Nearest-point bin lookup. A load word (mode 0) writes one table entry
// (point a, point b, bin) and gives no response. A query word (mode 1)
// scans entries 0 to entry_count-1 (at most the table depth) through one
// pipelined squared-distance unit fed by the table RAM at one read per
// cycle, keeps the first entry strictly below the running minimum (which
// starts at distance_limit), then rereads the chosen entry for its bin.
// The response word waits while the previous response word sits stalled,
// and no new request is taken until the response word is written.
// req_stall stays high for the whole scan. With no qualifying entry the
// response names entry 0 with within_limit low. The bin is negated when
// coord_b is below coord_a. Table contents are undefined until loaded, so
// load every scanned entry, and entry 0, before querying. Write the CSRs
// only while the block is idle.
module nearest_point_bin_lookup_unit import npbl_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_word_type              req_word,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_word_type              rsp_word,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PICK_RD,
      ST_PICK_WAIT
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [COUNT_BITS-1:0] entry_count_ff, entry_count_in;
   logic [LIMIT_BITS-1:0] distance_limit_ff, distance_limit_in;

   // Scan control.
   logic [SCAN_BITS-1:0]  issue_cnt_ff, issue_cnt_in;
   logic [SCAN_BITS-1:0]  scan_len_ff, scan_len_in;
   logic                  rd_valid_ff, rd_valid_in;
   logic [ADDR_BITS-1:0]  rd_index_ff, rd_index_in;
   logic [DIST_BITS-1:0]  best_ff, best_in;
   logic [ADDR_BITS-1:0]  pick_ff, pick_in;
   logic                  found_ff, found_in;

   // Query point and sign flip.
   logic signed [COORD_BITS-1:0] query_a_ff, query_a_in;
   logic signed [COORD_BITS-1:0] query_b_ff, query_b_in;
   logic                         negate_ff, negate_in;

   // Response register.
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   // Table RAM.
   logic                       ram_wr_en;
   logic [ADDR_BITS-1:0]       ram_rd_addr;
   logic [TABLE_WORD_BITS-1:0] ram_rd_data;
   table_word_type             load_word, table_word;
   logic                       load_in_range;

   logic signed [BIN_OUT_BITS-1:0] bin_wide;
   dist_out_type                   dist_out;

   assign load_word.point_a = req_word.coord_a;
   assign load_word.point_b = req_word.coord_b;
   assign load_word.bin     = req_word.entry_bin;
   assign table_word        = table_word_type'(ram_rd_data);

   // Drop loads that fall beyond the table.
   assign load_in_range = (32'(req_word.entry_index) < 32'(TABLE_DEPTH));
   assign ram_wr_en     = (state_ff == ST_IDLE) && req_valid &&
                          (req_word.mode == MODE_LOAD) && load_in_range;

   // Read the scan address, or the chosen entry once the scan is over.
   assign ram_rd_addr = ((state_ff == ST_PICK_RD) || (state_ff == ST_PICK_WAIT)) ?
                        pick_ff : issue_cnt_ff[ADDR_BITS-1:0];

   npbl_ram #(
      .WIDTH (TABLE_WORD_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ADDR_BITS'(req_word.entry_index)),
      .wr_data (TABLE_WORD_BITS'(load_word)),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   npbl_dist_unit u_dist (
      .clock    (clock),
      .reset    (reset),
      .in_valid (rd_valid_ff),
      .in_index (rd_index_ff),
      .entry_a  (table_word.point_a),
      .entry_b  (table_word.point_b),
      .query_a  (query_a_ff),
      .query_b  (query_b_ff),
      .dist_out (dist_out)
   );

   always_comb begin
      state_in          = state_ff;
      entry_count_in    = entry_count_ff;
      distance_limit_in = distance_limit_ff;
      issue_cnt_in      = issue_cnt_ff;
      scan_len_in       = scan_len_ff;
      rd_valid_in       = 1'b0;
      rd_index_in       = issue_cnt_ff[ADDR_BITS-1:0];
      best_in           = best_ff;
      pick_in           = pick_ff;
      found_in          = found_ff;
      query_a_in        = query_a_ff;
      query_b_in        = query_b_ff;
      negate_in         = negate_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_word_in       = rsp_word_ff;

      bin_wide = BIN_OUT_BITS'(table_word.bin);
      if (negate_ff) begin
         bin_wide = -bin_wide;
      end

      // Configuration writes.
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_ENTRY_COUNT:    entry_count_in    = csr_wdata[COUNT_BITS-1:0];
            CSR_DISTANCE_LIMIT: distance_limit_in = csr_wdata[LIMIT_BITS-1:0];
            default:            ;
         endcase
      end

      // Drop the response word once taken.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_word.mode == MODE_QUERY)) begin
               query_a_in   = req_word.coord_a;
               query_b_in   = req_word.coord_b;
               negate_in    = (req_word.coord_b < req_word.coord_a);
               best_in      = DIST_BITS'(distance_limit_ff);
               pick_in      = '0;
               found_in     = 1'b0;
               issue_cnt_in = '0;
               // Saturate the scan at the table depth.
               if (32'(entry_count_ff) > 32'(TABLE_DEPTH)) begin
                  scan_len_in = SCAN_BITS'(TABLE_DEPTH);
               end else begin
                  scan_len_in = SCAN_BITS'(entry_count_ff);
               end
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue_cnt_ff != scan_len_ff) begin
               rd_valid_in  = 1'b1;
               issue_cnt_in = issue_cnt_ff + 1'b1;
            end
            // Strictly below keeps the first of equal distances.
            if (dist_out.valid && (dist_out.distance < best_ff)) begin
               best_in  = dist_out.distance;
               pick_in  = dist_out.index;
               found_in = 1'b1;
            end
            if ((issue_cnt_ff == scan_len_ff) && !rd_valid_ff && !dist_out.busy) begin
               state_in = ST_PICK_RD;
            end
         end
         ST_PICK_RD: begin
            state_in = ST_PICK_WAIT;
         end
         ST_PICK_WAIT: begin
            // Hold here until the previous response word has left.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_word_in.bin_result    = bin_wide;
               rsp_word_in.nearest_index = INDEX_BITS'(pick_ff);
               rsp_word_in.within_limit  = found_ff;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      scan_len_ff <= scan_len_in;
      rd_index_ff <= rd_index_in;
      best_ff     <= best_in;
      pick_ff     <= pick_in;
      found_ff    <= found_in;
      query_a_ff  <= query_a_in;
      query_b_ff  <= query_b_in;
      negate_ff   <= negate_in;
      rsp_word_ff <= rsp_word_in;
      if (reset) begin
         state_ff          <= ST_IDLE;
         entry_count_ff    <= '0;
         distance_limit_ff <= LIMIT_RESET;
         issue_cnt_ff      <= '0;
         rd_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         entry_count_ff    <= entry_count_in;
         distance_limit_ff <= distance_limit_in;
         issue_cnt_ff      <= issue_cnt_in;
         rd_valid_ff       <= rd_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

### hdl/npbl_checker.sv
`include "nearest_point_bin_lookup_unit_macros.svh"

module npbl_checker import npbl_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input req_word_type req_word,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_word
);

   // A stalled response word stays put.
   `NPBL_ASSERT_NEXT(a_rsp_valid_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `NPBL_ASSERT_NEXT(a_rsp_word_hold, clock, reset, rsp_valid && rsp_stall, $stable(rsp_word))

   // An accepted query blocks the request side while it scans.
   `NPBL_ASSERT_NEXT(a_query_blocks, clock, reset, req_valid && !req_stall && req_word.mode, req_stall)

   // A miss always names entry zero.
   `NPBL_ASSERT_NOW(a_miss_entry_zero, clock, reset, rsp_valid && !rsp_word.within_limit, rsp_word.nearest_index == '0)

endmodule

bind nearest_point_bin_lookup_unit npbl_checker u_checker (.*);
